// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and controller/datapath types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int COLOR_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'd15;

  // Start points of the linear cell scan
  typedef enum logic [1:0] {
    SCAN_ZERO,
    SCAN_SECOND_ROW,
    SCAN_LAST_ROW
  } scan_sel_e;

  typedef struct packed {
    logic      load_item;
    logic      newline;
    logic      put;
    logic      rd_cell;
    logic      scan_ld;
    scan_sel_e scan_sel;
    logic      scan_inc;
    logic      scr_rd;
    logic      scr_wr;
    logic      blank_wr;
    logic      load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_newline;
    logic              wrap_pend;
    logic              at_bottom;
    logic              rd_in_range;
    logic              scan_last;
    logic              out_full;
  } tcw_sts_t;

endpackage

// File: hdl/tcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels of the text console writer: request, result, config.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::FUNC_W-1:0]  func;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::RROW_W-1:0]  read_row;
  logic [tcw_pkg::RCOL_W-1:0]  read_col;

  modport source (output valid, func, char_code, read_row, read_col, input ready);
  modport sink   (input valid, func, char_code, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::RROW_W-1:0]   cursor_row_out;
  logic [tcw_pkg::RCOL_W-1:0]   cursor_col_out;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::COLOR_W-1:0]  cell_color;

  modport source (output valid, cursor_row_out, cursor_col_out, cell_char, cell_color,
                  input ready);
  modport sink   (input valid, cursor_row_out, cursor_col_out, cell_char, cell_color,
                  output ready);
endinterface

interface tcw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::COLOR_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// ROWS x COLS character-cell console with cursor, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// A scroll copies every cell of rows 1..ROWS-1 up one row, with a read/write
// pair per copied cell on the single memory port pair, then blanks the last
// row; a clear blanks every cell, one cell write a cycle.
// One word in flight; the next is accepted once the result is registered.
// Reset clears cursor, color (15) and control; screen memory is not cleared.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o,
  tcw_cfg_if.sink    cfg_i
);

  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  assign cfg_i.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (in_i.func),
    .char_code_i      (in_i.char_code),
    .read_row_i       (in_i.read_row),
    .read_col_i       (in_i.read_col),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .cursor_row_out_o (out_o.cursor_row_out),
    .cursor_col_out_o (out_o.cursor_col_out),
    .cell_char_o      (out_o.cell_char),
    .cell_color_o     (out_o.cell_color)
  );

  // Busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("accepted a word while the previous one is in flight");

  a_result_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_o.valid)
    else $error("result loaded but not presented");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.put, cmd.scr_wr, cmd.blank_wr}))
    else $error("more than one memory write source");

  a_copy_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scr_wr |-> $past(cmd.scr_rd))
    else $error("scroll write without preceding read");

endmodule

// File: hdl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor, color register, scan counter and result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::tcw_cmd_t           cmd_i,
  output tcw_pkg::tcw_sts_t           sts_o,
  input  logic [tcw_pkg::FUNC_W-1:0]  func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::RROW_W-1:0]  read_row_i,
  input  logic [tcw_pkg::RCOL_W-1:0]  read_col_i,
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::COLOR_W-1:0] cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [tcw_pkg::RROW_W-1:0]  cursor_row_out_o,
  output logic [tcw_pkg::RCOL_W-1:0]  cursor_col_out_o,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0] cell_color_o
);

  localparam int N  = ROWS * COLS;
  localparam int AW = $clog2(N);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS + 1);
  localparam int CELL_W = tcw_pkg::COLOR_W + tcw_pkg::CHAR_W;

  logic [CELL_W-1:0] mem_q [N];
  logic [CELL_W-1:0] rdata_q;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [tcw_pkg::COLOR_W-1:0] color_q;
  logic [AW-1:0] scan_q, scan_d;

  logic [tcw_pkg::FUNC_W-1:0] func_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::RROW_W-1:0] rrow_q;
  logic [tcw_pkg::RCOL_W-1:0] rcol_q;

  logic out_valid_q, out_valid_d;
  logic [tcw_pkg::RROW_W-1:0]  orow_q;
  logic [tcw_pkg::RCOL_W-1:0]  ocol_q;
  logic [tcw_pkg::CHAR_W-1:0]  ochar_q;
  logic [tcw_pkg::COLOR_W-1:0] ocolor_q;

  logic              wen, ren, rd_in_range;
  logic [AW-1:0]     waddr, raddr, rd_addr, put_addr;
  logic [CELL_W-1:0] wdata;

  assign rd_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
  assign rd_addr     = AW'(int'(rrow_q) * COLS + int'(rcol_q));
  assign put_addr    = AW'(int'(row_q) * COLS + int'(col_q));

  // One write port shared by put, scroll copy and blanking
  always_comb begin
    wen   = cmd_i.put | cmd_i.scr_wr | cmd_i.blank_wr;
    waddr = scan_q;
    wdata = {color_q, tcw_pkg::CHAR_SPACE};
    if (cmd_i.put) begin
      waddr = put_addr;
      wdata = {color_q, char_q};
    end else if (cmd_i.scr_wr) begin
      waddr = scan_q - AW'(COLS);
      wdata = rdata_q;
    end
    ren   = cmd_i.scr_rd | cmd_i.rd_cell;
    raddr = cmd_i.scr_rd ? scan_q : rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.newline) begin
      col_d = '0;
      if (row_q != RW'(ROWS - 1)) begin
        row_d = row_q + 1'b1;
      end
    end else if (cmd_i.put) begin
      col_d = col_q + 1'b1;
    end
  end

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.scan_ld) begin
      case (cmd_i.scan_sel)
        tcw_pkg::SCAN_ZERO:       scan_d = '0;
        tcw_pkg::SCAN_SECOND_ROW: scan_d = AW'(COLS);
        tcw_pkg::SCAN_LAST_ROW:   scan_d = AW'(N - COLS);
        default:                  scan_d = '0;
      endcase
    end else if (cmd_i.scan_inc) begin
      scan_d = scan_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      color_q     <= tcw_pkg::COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (cmd_i.load_item) begin
      func_q <= func_i;
      char_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    if (cmd_i.load_out) begin
      orow_q <= tcw_pkg::RROW_W'(row_q);
      ocol_q <= tcw_pkg::RCOL_W'(col_q);
      if ((func_q == tcw_pkg::FUNC_READ) && rd_in_range) begin
        {ocolor_q, ochar_q} <= rdata_q;
      end else begin
        {ocolor_q, ochar_q} <= '0;
      end
    end
  end

  always_comb begin
    sts_o.func        = func_q;
    sts_o.is_newline  = (char_q == tcw_pkg::CHAR_NEWLINE);
    sts_o.wrap_pend   = (col_q >= CW'(COLS));
    sts_o.at_bottom   = (row_q == RW'(ROWS - 1));
    sts_o.rd_in_range = rd_in_range;
    sts_o.scan_last   = (scan_q == AW'(N - 1));
    sts_o.out_full    = out_valid_q && !out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_row_out_o = orow_q;
  assign cursor_col_out_o = ocol_q;
  assign cell_char_o      = ochar_q;
  assign cell_color_o     = ocolor_q;

endmodule

// File: hdl/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for put, newline/scroll, clear and read words.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCR_RD = 4'd2;
  localparam logic [3:0] S_SCR_WR = 4'd3;
  localparam logic [3:0] S_BLANK  = 4'd4;
  localparam logic [3:0] S_PUT    = 4'd5;
  localparam logic [3:0] S_DONE   = 4'd6;

  logic [3:0] state_q, state_d;
  logic       pend_put_q, pend_put_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    pend_put_d = pend_put_q;
    cmd_o      = '0;
    cmd_o.scan_sel = tcw_pkg::SCAN_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        pend_put_d = 1'b0;
        case (sts_i.func)
          tcw_pkg::FUNC_PUT: begin
            pend_put_d = !sts_i.is_newline;
            if (sts_i.is_newline || sts_i.wrap_pend) begin
              cmd_o.newline = 1'b1;
              if (sts_i.at_bottom) begin
                cmd_o.scan_ld  = 1'b1;
                cmd_o.scan_sel = tcw_pkg::SCAN_SECOND_ROW;
                state_d        = S_SCR_RD;
              end else if (sts_i.is_newline) begin
                state_d = S_DONE;
              end else begin
                state_d = S_PUT;
              end
            end else begin
              state_d = S_PUT;
            end
          end
          tcw_pkg::FUNC_CLEAR: begin
            cmd_o.scan_ld  = 1'b1;
            cmd_o.scan_sel = tcw_pkg::SCAN_ZERO;
            state_d        = S_BLANK;
          end
          tcw_pkg::FUNC_READ: begin
            cmd_o.rd_cell = sts_i.rd_in_range;
            state_d       = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      // Copy rows 1..last up one row, one cell per read/write pair
      S_SCR_RD: begin
        cmd_o.scr_rd = 1'b1;
        state_d      = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.scr_wr = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.scan_ld  = 1'b1;
          cmd_o.scan_sel = tcw_pkg::SCAN_LAST_ROW;
          state_d        = S_BLANK;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_SCR_RD;
        end
      end
      S_BLANK: begin
        cmd_o.blank_wr = 1'b1;
        if (sts_i.scan_last) begin
          state_d = pend_put_q ? S_PUT : S_DONE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_put_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_put_q <= pend_put_d;
    end
  end

endmodule
